>>> src/smavg_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sensor moving average block
package smavg_pkg;

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned AVG_W    = 8;

	// op codes of an input word
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// value reported when the average is above the top limit
	localparam logic [AVG_W-1:0] CLAMP_VALUE   = 8'd255;
	localparam logic [AVG_W-1:0] TOP_LIMIT_RST = 8'd255;

	typedef struct packed {
		logic                op;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [AVG_W-1:0] average;
		logic             not_empty;
	} res_t;

endpackage

>>> src/sensor_moving_average_core.sv
`timescale 1ns / 1ps
// top level of the sensor moving average filter
//
//  channel   handshake             payload
//  -------   -------------------   -------------------------
//  input     in_valid / in_stall   op, sample
//  output    out_valid / out_stall average, not_empty
//  config    cfg_valid / cfg_ready cfg_top_limit
//
// one word per cycle sustained while the output is not stalled; a word passes the input stage and the result register
// on its way to the port; the running sum adds new, subtracts evicted once full, clears on flush, one ring read a cycle
// the evicted sample is prefetched from the ring ram through its registered read port
// reset clears the fill count, pointer and sum; ring contents are never read unfilled
// a stalled output holds the result and backs pressure up through the input stage
module sensor_moving_average_core #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned SHIFT = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input words
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [smavg_pkg::SAMPLE_W-1:0]   sample,
	// result words
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [smavg_pkg::AVG_W-1:0]      average,
	output logic                             not_empty,
	// top limit register write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [smavg_pkg::AVG_W-1:0]      cfg_top_limit
);
	import smavg_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic             out_valid_q;
	res_t             res_q;
	res_t             res_d;
	logic [AVG_W-1:0] top_limit_q;
	logic             out_free;
	logic             fire;
	logic             accept;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_limit_q <= TOP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			top_limit_q <= cfg_top_limit;
		end
	end

	// output register can load when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	// word in the input stage is processed and moves to the output register
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op     <= op;
			item_s1.sample <= sample;
		end
	end

	// ring state and average for the word in the input stage
	smavg_dp #(
		.DEPTH (DEPTH),
		.SHIFT (SHIFT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.top_limit (top_limit_q),
		.result    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = res_q.average;
	assign not_empty = res_q.not_empty;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled while output register free");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed word did not reach the result register");

endmodule

>>> src/smavg_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module smavg_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/smavg_dp.sv
`timescale 1ns / 1ps
// ring state, running sum and average computation
module smavg_dp #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned SHIFT = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  smavg_pkg::item_t                item,
	input  logic [smavg_pkg::AVG_W-1:0]     top_limit,
	output smavg_pkg::res_t                 result
);
	import smavg_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W = $clog2(DEPTH * 255 + 1);

	logic [CNT_W-1:0]    count_q, count_d;
	logic [PTR_W-1:0]    oldest_q, oldest_d, oldest_inc;
	logic [SUM_W-1:0]    sum_q, sum_d;
	logic                full, empty;
	logic                we;
	logic [PTR_W-1:0]    waddr, raddr;
	logic [SAMPLE_W-1:0] evict;
	logic [SUM_W+AVG_W-1:0] shifted;
	logic [AVG_W-1:0]    avg;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign oldest_inc = (oldest_q == PTR_W'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	// oldest stays at zero until the ring is full
	assign waddr = full ? oldest_q : count_q[PTR_W-1:0];
	assign we    = fire && (item.op == OP_PUSH);
	// prefetch the slot that will be evicted by the next push
	assign raddr = fire ? oldest_d : oldest_q;

	smavg_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (item.sample),
		.raddr (raddr),
		.rdata (evict)
	);

	always_comb begin
		count_d  = count_q;
		oldest_d = oldest_q;
		sum_d    = sum_q;
		if (item.op == OP_FLUSH) begin
			count_d  = '0;
			oldest_d = '0;
			sum_d    = '0;
		end else if (empty) begin
			count_d = CNT_W'(1);
			sum_d   = SUM_W'(item.sample);
		end else if (full) begin
			oldest_d = oldest_inc;
			sum_d    = sum_q - SUM_W'(evict) + SUM_W'(item.sample);
		end else begin
			count_d = count_q + 1'b1;
			sum_d   = sum_q + SUM_W'(item.sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			oldest_q <= '0;
			sum_q    <= '0;
		end else if (fire) begin
			count_q  <= count_d;
			oldest_q <= oldest_d;
			sum_q    <= sum_d;
		end
	end

	assign shifted = {{AVG_W{1'b0}}, sum_d} >> SHIFT;
	assign avg     = shifted[AVG_W-1:0];

	always_comb begin
		result.average   = (avg > top_limit) ? CLAMP_VALUE : avg;
		result.not_empty = (count_d != '0);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above ring depth");

	a_oldest_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(oldest_q != '0) |-> full)
		else $error("oldest pointer moved before ring filled");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.op == OP_FLUSH) |=> (count_q == '0 && sum_q == '0))
		else $error("flush did not clear ring state");

	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && full && item.op == OP_PUSH) |=> full)
		else $error("push into full ring changed the fill count");

endmodule
